### hdl/top_n_sorted_insert_table_macros.svh
// assertion macros for the sorted insert table
`ifndef TOP_N_SORTED_INSERT_TABLE_MACROS_SVH
`define TOP_N_SORTED_INSERT_TABLE_MACROS_SVH

// same-cycle implication
`define TNSIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TNSIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tnsit_pkg.sv
// shared types and constants of the sorted insert table
`default_nettype none

package tnsit_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [23:0] tag;
    logic [15:0] key;
    logic [1:0]  class_code;
    logic [2:0]  index;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  rank;
    logic [3:0]  count;
    logic [23:0] tag_out;
    logic [15:0] key_out;
    logic [1:0]  class_out;
  } out_word_t;

  typedef struct packed {
    logic [15:0] key;
    logic [23:0] tag;
    logic [1:0]  cls;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### hdl/tnsit_seq.sv
// sequencer that walks the entry memory for inserts and reads
`default_nettype none

module tnsit_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire tnsit_pkg::in_word_t in_word,
  input  wire tnsit_pkg::entry_t   rdata,
  output tnsit_pkg::mem_req_t      req,
  output logic                     busy,
  output logic                     done,
  output tnsit_pkg::out_word_t     result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_REJ   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;

  logic [2:0]                     state, state_next;
  logic [tnsit_pkg::IDX_W-1:0]    slot, slot_next;
  logic [tnsit_pkg::CNT_W-1:0]    fill, fill_next;
  tnsit_pkg::in_word_t            item, item_next;
  logic                           done_next;
  tnsit_pkg::out_word_t           result_next;
  tnsit_pkg::entry_t              new_entry;
  logic                           idx_ok;

  assign new_entry = '{key: item.key, tag: item.tag, cls: item.class_code};
  assign idx_ok    = 8'(item.index) < 8'(fill);
  assign busy      = state != S_IDLE;

  always_comb begin
    state_next  = state;
    slot_next   = slot;
    fill_next   = fill;
    item_next   = item;
    done_next   = 1'b0;
    result_next = result;
    req         = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          item_next = in_word;
          if (in_word.cmd == tnsit_pkg::CMD_READ) begin
            req.raddr  = tnsit_pkg::IDX_W'(in_word.index);
            state_next = S_READ;
          end else if (fill == tnsit_pkg::CNT_W'(tnsit_pkg::CAPACITY)) begin
            req.raddr  = tnsit_pkg::IDX_W'(tnsit_pkg::CAPACITY - 1);
            state_next = S_REJ;
          end else if (fill == '0) begin
            req.we      = 1'b1;
            req.waddr   = '0;
            req.wdata   = '{key: in_word.key, tag: in_word.tag, cls: in_word.class_code};
            fill_next   = tnsit_pkg::CNT_W'(1);
            result_next = '0;
            result_next.ok    = 1'b1;
            result_next.count = 4'd1;
            done_next   = 1'b1;
          end else begin
            slot_next  = tnsit_pkg::IDX_W'(fill);
            fill_next  = fill + tnsit_pkg::CNT_W'(1);
            req.raddr  = tnsit_pkg::IDX_W'(fill - tnsit_pkg::CNT_W'(1));
            state_next = S_CMP;
          end
        end
      end
      S_READ: begin
        result_next       = '0;
        result_next.count = 4'(fill);
        if (idx_ok) begin
          result_next.ok        = 1'b1;
          result_next.tag_out   = rdata.tag;
          result_next.key_out   = rdata.key;
          result_next.class_out = rdata.cls;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      S_REJ: begin
        if (item.key <= rdata.key) begin
          result_next       = '0;
          result_next.count = 4'(fill);
          done_next         = 1'b1;
          state_next        = S_IDLE;
        end else begin
          slot_next  = tnsit_pkg::IDX_W'(tnsit_pkg::CAPACITY - 1);
          req.raddr  = tnsit_pkg::IDX_W'(tnsit_pkg::CAPACITY - 2);
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        req.we = 1'b1;
        if (item.key > rdata.key) begin
          req.waddr = slot;
          req.wdata = rdata;
          slot_next = slot - tnsit_pkg::IDX_W'(1);
          if (slot == tnsit_pkg::IDX_W'(1)) begin
            state_next = S_PLACE;
          end else begin
            req.raddr = slot - tnsit_pkg::IDX_W'(2);
          end
        end else begin
          req.waddr         = slot;
          req.wdata         = new_entry;
          result_next       = '0;
          result_next.ok    = 1'b1;
          result_next.rank  = 3'(slot);
          result_next.count = 4'(fill);
          done_next         = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_PLACE: begin
        req.we            = 1'b1;
        req.waddr         = slot;
        req.wdata         = new_entry;
        result_next       = '0;
        result_next.ok    = 1'b1;
        result_next.rank  = 3'(slot);
        result_next.count = 4'(fill);
        done_next         = 1'b1;
        state_next        = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
    slot   <= slot_next;
    item   <= item_next;
    result <= result_next;
  end

endmodule

`default_nettype wire

### hdl/top_n_sorted_insert_table.sv
// top level of the sorted insert table: entry memory and sequencer
// A word on in_word is taken at a rising edge where start is high and busy
// is low. cmd insert places the entry in descending key order (ties after
// equal keys), dropping the last entry when the table is full, or rejects
// it when the table is full and the key is not above the last key. cmd read
// returns the entry at index when index is below the fill count.
// Each word gives one result word on result, valid for exactly one cycle
// while done is high; the receiver cannot stall and must take it then.
// Entries live in one memory of CAPACITY words with a registered read port.
// Inserts walk it from the bottom, one entry moved down per cycle, with busy
// high while they walk; a full table first checks the last key in S_REJ,
// where a reject ends, before the walk. An insert into an empty table
// keeps busy low. A read keeps busy high while in S_READ. done is high for
// the first cycle with busy low (the cycle after the accept for an insert
// into an empty table), and a new word may be taken at the edge ending it.
// Synchronous reset empties the table; memory contents are not cleared and
// entries at or beyond the fill count are never shown.
`default_nettype none
`include "top_n_sorted_insert_table_macros.svh"

module top_n_sorted_insert_table (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire tnsit_pkg::in_word_t  in_word,
  output logic                      done,
  output tnsit_pkg::out_word_t      result
);

  tnsit_pkg::entry_t   mem [tnsit_pkg::CAPACITY];
  tnsit_pkg::entry_t   rdata;
  tnsit_pkg::mem_req_t req;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

  tnsit_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_word (in_word),
    .rdata   (rdata),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  `TNSIT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted word stalled")
  `TNSIT_ASSERT_NOW(a_done_idle, done, !busy, "result while still busy")
  `TNSIT_ASSERT_NOW(a_no_spurious, done, $past(busy) || $past(start), "result without a word")
  `TNSIT_ASSERT_NOW(a_reject_clean, done && !result.ok, result.rank == 3'd0, "rank on failure")

endmodule

`default_nettype wire
